### hw/rtl/vms_pkg.sv
// Package for the Vole machine step block: beat types, codes and the microcode table.
// Used by vole_machine_step; has no dependencies of its own.
package vms_pkg;

	// Machine sizes.
	localparam int NUM_REGISTERS = 16;
	localparam int MEMORY_BYTES  = 256;
	localparam int REG_IDX_W     = $clog2(NUM_REGISTERS);
	localparam int MEM_ADDR_W    = $clog2(MEMORY_BYTES);
	localparam int BYTE_W        = 8;

	// Input beat functions.
	localparam logic [1:0] FN_WRITE   = 2'd0;
	localparam logic [1:0] FN_EXEC    = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;
	localparam logic [1:0] FN_READ    = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_HALTED  = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	// Opcodes (top nibble of the instruction word) and the halt word.
	localparam logic [3:0]  OP_LOAD  = 4'h1;
	localparam logic [3:0]  OP_LDI   = 4'h2;
	localparam logic [3:0]  OP_STORE = 4'h3;
	localparam logic [3:0]  OP_MOVE  = 4'h4;
	localparam logic [3:0]  OP_ADD   = 4'h5;
	localparam logic [3:0]  OP_JUMP  = 4'hB;
	localparam logic [15:0] HALT_WORD = 16'hC000;

	// Payload of an input beat.
	typedef struct packed {
		logic [1:0]            func;
		logic [MEM_ADDR_W-1:0] mem_addr;
		logic [BYTE_W-1:0]     mem_data;
		logic [REG_IDX_W-1:0]  reg_index;
	} item_t;

	// Payload of a result beat.
	typedef struct packed {
		logic [1:0]            status;
		logic [MEM_ADDR_W-1:0] pc;
		logic [15:0]           instruction;
		logic                  print_valid;
		logic [BYTE_W-1:0]     print_value;
		logic [BYTE_W-1:0]     read_value;
	} result_t;

	// Microcode step numbers. Steps that follow one another by plain
	// sequencing are numbered consecutively.
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t SP_IDLE  = 5'd0;
	localparam step_t SP_WRITE = 5'd1;
	localparam step_t SP_RST   = 5'd2;
	localparam step_t SP_READ  = 5'd3;
	localparam step_t SP_HALTX = 5'd4;
	localparam step_t SP_F0    = 5'd5;
	localparam step_t SP_F1    = 5'd6;
	localparam step_t SP_F2    = 5'd7;
	localparam step_t SP_LD0   = 5'd8;
	localparam step_t SP_LD1   = 5'd9;
	localparam step_t SP_LDI   = 5'd10;
	localparam step_t SP_ST    = 5'd11;
	localparam step_t SP_MOV   = 5'd12;
	localparam step_t SP_ADD0  = 5'd13;
	localparam step_t SP_ADD1  = 5'd14;
	localparam step_t SP_BR    = 5'd15;
	localparam step_t SP_HLT   = 5'd16;
	localparam step_t SP_ILL   = 5'd17;

	// Control word field encodings.
	typedef enum logic [1:0] {MA_PC, MA_PC1, MA_XY, MA_IN} ma_sel_t;
	typedef enum logic [0:0] {WD_IN, WD_REG} wd_sel_t;
	typedef enum logic [1:0] {RS_R, RS_S, RS_T, RS_IDX} rs_sel_t;
	typedef enum logic [0:0] {DST_R, DST_T} dst_sel_t;
	typedef enum logic [1:0] {SRC_MEM, SRC_XY, SRC_RD, SRC_SUM} src_sel_t;
	typedef enum logic [1:0] {PC_KEEP, PC_NEXT, PC_BR, PC_START} pc_op_t;
	typedef enum logic [1:0] {SQ_NEXT, SQ_FUNC, SQ_OP, SQ_DONE} seq_t;

	// One control word of the microprogram.
	typedef struct packed {
		ma_sel_t    ma_sel;
		logic       mem_we;
		wd_sel_t    wd_sel;
		rs_sel_t    rs_sel;
		logic       ld_ir_hi;
		logic       ld_ir_lo;
		logic       ld_a;
		logic       rf_we;
		dst_sel_t   rf_dst;
		src_sel_t   rf_src;
		pc_op_t     pc_op;
		logic       halt_set;
		logic       halt_clr;
		logic [1:0] status;
		logic       show_ir;
		logic       print_en;
		logic       read_en;
		seq_t       seq;
	} cw_t;

	localparam cw_t CW_NOP = '{
		ma_sel: MA_PC, mem_we: 1'b0, wd_sel: WD_IN, rs_sel: RS_R,
		ld_ir_hi: 1'b0, ld_ir_lo: 1'b0, ld_a: 1'b0, rf_we: 1'b0,
		rf_dst: DST_R, rf_src: SRC_MEM, pc_op: PC_KEEP,
		halt_set: 1'b0, halt_clr: 1'b0, status: ST_DONE,
		show_ir: 1'b0, print_en: 1'b0, read_en: 1'b0, seq: SQ_DONE
	};

	// The microprogram: one control word for each step.
	function automatic cw_t ucode(input step_t step);
		cw_t cw;
		cw = CW_NOP;
		case (step)
			SP_IDLE: begin
				cw.seq = SQ_FUNC;
			end
			SP_WRITE: begin
				cw.ma_sel = MA_IN;
				cw.mem_we = 1'b1;
				cw.wd_sel = WD_IN;
			end
			SP_RST: begin
				cw.pc_op    = PC_START;
				cw.halt_clr = 1'b1;
			end
			SP_READ: begin
				cw.rs_sel  = RS_IDX;
				cw.read_en = 1'b1;
			end
			SP_HALTX: begin
				cw.status = ST_HALTED;
			end
			SP_F0: begin
				cw.ma_sel = MA_PC;
				cw.seq    = SQ_NEXT;
			end
			SP_F1: begin
				cw.ma_sel   = MA_PC1;
				cw.ld_ir_hi = 1'b1;
				cw.seq      = SQ_NEXT;
			end
			SP_F2: begin
				cw.ma_sel   = MA_XY;
				cw.ld_ir_lo = 1'b1;
				cw.seq      = SQ_OP;
			end
			SP_LD0: begin
				cw.ma_sel = MA_XY;
				cw.seq    = SQ_NEXT;
			end
			SP_LD1: begin
				cw.ma_sel  = MA_XY;
				cw.rf_we   = 1'b1;
				cw.rf_dst  = DST_R;
				cw.rf_src  = SRC_MEM;
				cw.pc_op   = PC_NEXT;
				cw.show_ir = 1'b1;
			end
			SP_LDI: begin
				cw.rf_we   = 1'b1;
				cw.rf_dst  = DST_R;
				cw.rf_src  = SRC_XY;
				cw.pc_op   = PC_NEXT;
				cw.show_ir = 1'b1;
			end
			SP_ST: begin
				cw.ma_sel   = MA_XY;
				cw.mem_we   = 1'b1;
				cw.wd_sel   = WD_REG;
				cw.rs_sel   = RS_R;
				cw.print_en = 1'b1;
				cw.pc_op    = PC_NEXT;
				cw.show_ir  = 1'b1;
			end
			SP_MOV: begin
				cw.rs_sel  = RS_S;
				cw.rf_we   = 1'b1;
				cw.rf_dst  = DST_T;
				cw.rf_src  = SRC_RD;
				cw.pc_op   = PC_NEXT;
				cw.show_ir = 1'b1;
			end
			SP_ADD0: begin
				cw.rs_sel = RS_S;
				cw.ld_a   = 1'b1;
				cw.seq    = SQ_NEXT;
			end
			SP_ADD1: begin
				cw.rs_sel  = RS_T;
				cw.rf_we   = 1'b1;
				cw.rf_dst  = DST_R;
				cw.rf_src  = SRC_SUM;
				cw.pc_op   = PC_NEXT;
				cw.show_ir = 1'b1;
			end
			SP_BR: begin
				cw.rs_sel  = RS_R;
				cw.pc_op   = PC_BR;
				cw.show_ir = 1'b1;
			end
			SP_HLT: begin
				cw.halt_set = 1'b1;
				cw.status   = ST_HALTED;
				cw.show_ir  = 1'b1;
			end
			SP_ILL: begin
				cw.status  = ST_ILLEGAL;
				cw.show_ir = 1'b1;
			end
			default: begin
				cw = CW_NOP;
			end
		endcase
		return cw;
	endfunction

endpackage

### hw/rtl/vole_machine_step.sv
// Top level of the Vole machine step block: microcode sequencer, register file and datapath.
// Depends on vms_pkg and on vms_ram for the 256-byte main memory.

// One item at a time is taken, each ended by exactly one result beat. A memory write,
// restart, register read or execute while halted goes from idle through its working
// step back to idle; an executed instruction passes the fetch steps and then its opcode
// steps. The sequence is set by the single-port main memory with its registered read:
// two instruction byte reads and one data access go through it one after another, and
// the microprogram spends one step on each. After reset the block clears all 256 bytes
// of main memory and takes no item until that is done; the configuration port stays
// open throughout. Results wait in an output register, so the next item is taken while
// a result is still held; the start address may be written at any time.
module vole_machine_step
	import vms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	// Sequencer and machine state.
	step_t                 step_q;
	logic                  clr_q;
	logic [MEM_ADDR_W-1:0] clr_cnt_q;
	logic [MEM_ADDR_W-1:0] start_q;
	logic [MEM_ADDR_W-1:0] pc_q;
	logic                  halted_q;
	logic [BYTE_W-1:0]     rf_q [NUM_REGISTERS];
	item_t                 in_q;
	logic [15:0]           ir_q;
	logic [BYTE_W-1:0]     a_q;
	result_t               res_q;
	logic                  res_valid_q;

	// Datapath signals.
	cw_t                   cw;
	logic                  accept;
	logic                  adv;
	step_t                 step_nxt;
	step_t                 func_target;
	step_t                 op_target;
	logic [15:0]           word_w;
	logic [REG_IDX_W-1:0]  r_idx;
	logic [REG_IDX_W-1:0]  s_idx;
	logic [REG_IDX_W-1:0]  t_idx;
	logic [REG_IDX_W-1:0]  rd_idx;
	logic [REG_IDX_W-1:0]  dst_idx;
	logic [BYTE_W-1:0]     rd_data;
	logic [BYTE_W-1:0]     rf_wdata;
	logic [MEM_ADDR_W-1:0] xy;
	logic                  xy_zero;
	logic [MEM_ADDR_W-1:0] pc_inc;
	logic [MEM_ADDR_W-1:0] pc_nxt;
	logic                  ram_we;
	logic [MEM_ADDR_W-1:0] ram_addr;
	logic [BYTE_W-1:0]     ram_wdata;
	logic [BYTE_W-1:0]     ram_rdata;
	result_t               res_w;

	// Current control word from the microprogram.
	assign cw = ucode(step_q);

	// Input handshake: items are taken only in the idle step once memory is cleared.
	assign item_stall = clr_q || (step_q != SP_IDLE);
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// A finishing step waits while the previous result is still held.
	assign adv = !((cw.seq == SQ_DONE) && res_valid_q && result_stall);

	// Instruction fields.
	assign r_idx   = ir_q[11:8];
	assign s_idx   = ir_q[7:4];
	assign t_idx   = ir_q[3:0];
	assign xy      = ir_q[7:0];
	assign xy_zero = (xy == '0);

	// Register file read port and write data.
	always_comb begin
		case (cw.rs_sel)
			RS_R:    rd_idx = r_idx;
			RS_S:    rd_idx = s_idx;
			RS_T:    rd_idx = t_idx;
			RS_IDX:  rd_idx = in_q.reg_index;
			default: rd_idx = r_idx;
		endcase
		rd_data = rf_q[rd_idx];
		dst_idx = (cw.rf_dst == DST_T) ? t_idx : r_idx;
		case (cw.rf_src)
			SRC_MEM: rf_wdata = ram_rdata;
			SRC_XY:  rf_wdata = xy;
			SRC_RD:  rf_wdata = rd_data;
			SRC_SUM: rf_wdata = a_q + rd_data;
			default: rf_wdata = ram_rdata;
		endcase
	end

	// Program counter update.
	assign pc_inc = pc_q + MEM_ADDR_W'(2);
	always_comb begin
		case (cw.pc_op)
			PC_KEEP:  pc_nxt = pc_q;
			PC_NEXT:  pc_nxt = pc_inc;
			PC_BR:    pc_nxt = (rd_data == rf_q[0]) ? xy : pc_inc;
			PC_START: pc_nxt = start_q;
			default:  pc_nxt = pc_q;
		endcase
	end

	// Main memory port: the clearing pass owns it after reset.
	always_comb begin
		case (cw.ma_sel)
			MA_PC:   ram_addr = pc_q;
			MA_PC1:  ram_addr = pc_q + MEM_ADDR_W'(1);
			MA_XY:   ram_addr = xy;
			MA_IN:   ram_addr = in_q.mem_addr;
			default: ram_addr = pc_q;
		endcase
		ram_wdata = (cw.wd_sel == WD_REG) ? rd_data : in_q.mem_data;
		ram_we    = cw.mem_we && adv && !(cw.print_en && xy_zero);
		if (clr_q) begin
			ram_addr  = clr_cnt_q;
			ram_wdata = '0;
			ram_we    = 1'b1;
		end
	end

	vms_ram #(
		.DATA_W(BYTE_W),
		.DEPTH (MEMORY_BYTES)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Jump targets: by input function from idle, by opcode after the fetch.
	assign word_w = {ir_q[15:8], ram_rdata};
	always_comb begin
		case (item.func)
			FN_WRITE:   func_target = SP_WRITE;
			FN_EXEC:    func_target = halted_q ? SP_HALTX : SP_F0;
			FN_RESTART: func_target = SP_RST;
			FN_READ:    func_target = SP_READ;
			default:    func_target = SP_IDLE;
		endcase
		if (word_w == HALT_WORD) begin
			op_target = SP_HLT;
		end else begin
			case (word_w[15:12])
				OP_LOAD:  op_target = SP_LD0;
				OP_LDI:   op_target = SP_LDI;
				OP_STORE: op_target = SP_ST;
				OP_MOVE:  op_target = SP_MOV;
				OP_ADD:   op_target = SP_ADD0;
				OP_JUMP:  op_target = SP_BR;
				default:  op_target = SP_ILL;
			endcase
		end
	end

	// Next step of the sequencer.
	always_comb begin
		case (cw.seq)
			SQ_NEXT: step_nxt = step_q + STEP_W'(1);
			SQ_FUNC: step_nxt = accept ? func_target : SP_IDLE;
			SQ_OP:   step_nxt = op_target;
			SQ_DONE: step_nxt = SP_IDLE;
			default: step_nxt = SP_IDLE;
		endcase
		if (!adv) begin
			step_nxt = step_q;
		end
	end

	// Result beat assembled in the finishing step.
	always_comb begin
		res_w             = '0;
		res_w.status      = cw.status;
		res_w.pc          = pc_nxt;
		res_w.instruction = cw.show_ir ? ir_q : 16'h0000;
		res_w.print_valid = cw.print_en && xy_zero;
		res_w.print_value = (cw.print_en && xy_zero) ? rd_data : '0;
		res_w.read_value  = cw.read_en ? rd_data : '0;
	end

	// Control state, program counter and register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= SP_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			start_q     <= '0;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGISTERS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			step_q <= step_nxt;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + MEM_ADDR_W'(1);
				if (clr_cnt_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg_valid) begin
				start_q <= cfg_data;
			end
			if (adv) begin
				pc_q <= pc_nxt;
				if (cw.halt_set) begin
					halted_q <= 1'b1;
				end else if (cw.halt_clr) begin
					halted_q <= 1'b0;
				end
				if (cw.rf_we) begin
					rf_q[dst_idx] <= rf_wdata;
				end
			end
			if ((cw.seq == SQ_DONE) && adv) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured item, instruction word, operand and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= item;
		end
		if (cw.ld_ir_hi) begin
			ir_q[15:8] <= ram_rdata;
		end
		if (cw.ld_ir_lo) begin
			ir_q[7:0] <= ram_rdata;
		end
		if (cw.ld_a) begin
			a_q <= rd_data;
		end
		if ((cw.seq == SQ_DONE) && adv) begin
			res_q <= res_w;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### hw/rtl/vms_ram.sv
// Generic single-port RAM with a registered read, one access per cycle.
// No dependencies.
module vms_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write on enable; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
